// ===== design/pbr_pkg.sv =====
// shared types and constants of the printer column renderer
`default_nettype none

package pbr_pkg;

  localparam logic [7:0] ESC_CODE     = 8'd27;
  localparam logic [7:0] ESC_RESET    = 8'd255;
  localparam logic [7:0] ESC_WIDE     = 8'd253;
  localparam logic [7:0] ESC_NARROW   = 8'd252;
  localparam logic [7:0] ESC_ULINE    = 8'd251;
  localparam logic [7:0] ESC_NO_ULINE = 8'd250;
  localparam logic [7:0] ESC_NOP_MIN  = 8'd248;
  localparam logic [7:0] RAW_MAX      = 8'd166;
  localparam logic [7:0] CODE_EOT     = 8'd4;
  localparam logic [7:0] CODE_LF      = 8'd10;
  localparam logic [7:0] ULINE_BIT    = 8'h80;
  localparam logic [7:0] SUB_RESET    = 8'd127;

  localparam int FONT_AW     = 11;
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 4;

  localparam logic [2:0] CMD_FONT_WR  = 3'd0;
  localparam logic [2:0] CMD_RAW      = 3'd1;
  localparam logic [2:0] CMD_LINE_END = 3'd2;
  localparam logic [2:0] CMD_GLYPH    = 3'd3;
  localparam logic [2:0] CMD_CLEAR    = 3'd4;

  localparam logic [1:0] KIND_COLUMN   = 2'd0;
  localparam logic [1:0] KIND_LINE_END = 2'd1;
  localparam logic [1:0] KIND_FEED     = 2'd2;

  typedef struct packed {
    logic [2:0]         code;
    logic [FONT_AW-1:0] addr;
    logic [7:0]         data;
    logic               gvalid;
    logic               wide;
    logic               ul;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] column_index;
    logic [7:0] column_bits;
    logic [7:0] line_width;
    logic       overflowed;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

// ===== design/pbr_ram.sv =====
// generic single-port-write ram with registered read
`default_nettype none

module pbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1120,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/pbr_fifo.sv =====
// small register fifo used for the command queue and the result queue
`default_nettype none

module pbr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== design/pbr_front.sv =====
// front end: accepts stream bytes and font writes, tracks modes, issues commands
`default_nettype none

module pbr_front #(
  parameter int GLYPH_WIDTH = 5,
  parameter int FIRST_CODE  = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_push,
  input  wire logic                         in_op,
  input  wire logic [7:0]                   in_data_byte,
  input  wire logic [pbr_pkg::FONT_AW-1:0]  in_font_address,
  input  wire logic [7:0]                   in_font_column,
  input  wire logic                         cfg_wr,
  input  wire logic [7:0]                   cfg_data,
  input  wire logic                         q_full,
  output logic                              q_push,
  output pbr_pkg::cmd_t                     q_cmd
);

  localparam int STORE_DEPTH = (256 - FIRST_CODE) * GLYPH_WIDTH;

  logic       esc_r, esc_nxt;
  logic       wide_r, wide_nxt;
  logic       ul_r, ul_nxt;
  logic [7:0] raw_left_r, raw_left_nxt;
  logic [7:0] sub_r;
  logic       accept;
  logic       use_glyph;
  logic [7:0] c;
  logic [7:0] gcode;
  logic [7:0] goff;
  logic       gvalid;

  assign accept = in_push && !q_full;
  assign c      = in_data_byte;
  assign gvalid = ({1'b0, gcode} >= 9'(FIRST_CODE));
  assign goff   = gcode - 8'(FIRST_CODE);

  always_comb begin
    esc_nxt      = esc_r;
    wide_nxt     = wide_r;
    ul_nxt       = ul_r;
    raw_left_nxt = raw_left_r;
    q_push       = 1'b0;
    q_cmd        = '0;
    use_glyph    = 1'b0;
    gcode        = sub_r;
    if (accept) begin
      if (in_op) begin
        if ({1'b0, in_font_address} < 12'(STORE_DEPTH)) begin
          q_push     = 1'b1;
          q_cmd.code = pbr_pkg::CMD_FONT_WR;
          q_cmd.addr = in_font_address;
          q_cmd.data = in_font_column;
        end
      end else if (raw_left_r == '0 && c == pbr_pkg::ESC_CODE) begin
        esc_nxt = 1'b1;
      end else if (esc_r) begin
        esc_nxt = 1'b0;
        priority if (c == pbr_pkg::ESC_RESET) begin
          wide_nxt     = 1'b0;
          ul_nxt       = 1'b0;
          raw_left_nxt = '0;
          q_push       = 1'b1;
          q_cmd.code   = pbr_pkg::CMD_CLEAR;
        end else if (c == pbr_pkg::ESC_WIDE) begin
          wide_nxt = 1'b1;
        end else if (c == pbr_pkg::ESC_NARROW) begin
          wide_nxt = 1'b0;
        end else if (c == pbr_pkg::ESC_ULINE) begin
          ul_nxt = 1'b1;
        end else if (c == pbr_pkg::ESC_NO_ULINE) begin
          ul_nxt = 1'b0;
        end else if (c >= pbr_pkg::ESC_NOP_MIN) begin
          // self-test and charset selections ignored
        end else if (c != '0 && c <= pbr_pkg::RAW_MAX) begin
          raw_left_nxt = c;
        end else begin
          use_glyph = 1'b1;
        end
      end else if (raw_left_r != '0) begin
        raw_left_nxt = raw_left_r - 1'b1;
        q_push       = 1'b1;
        q_cmd.code   = pbr_pkg::CMD_RAW;
        q_cmd.data   = c;
      end else if (c == pbr_pkg::CODE_EOT || c == pbr_pkg::CODE_LF) begin
        q_push     = 1'b1;
        q_cmd.code = pbr_pkg::CMD_LINE_END;
      end else begin
        use_glyph = 1'b1;
        if ({1'b0, c} >= 9'(FIRST_CODE)) begin
          gcode = c;
        end
      end
    end
    if (use_glyph) begin
      q_push       = 1'b1;
      q_cmd.code   = pbr_pkg::CMD_GLYPH;
      q_cmd.gvalid = gvalid;
      q_cmd.addr   = gvalid ? pbr_pkg::FONT_AW'(goff) * pbr_pkg::FONT_AW'(GLYPH_WIDTH) : '0;
      q_cmd.wide   = wide_r;
      q_cmd.ul     = ul_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r      <= 1'b0;
      wide_r     <= 1'b0;
      ul_r       <= 1'b0;
      raw_left_r <= '0;
      sub_r      <= pbr_pkg::SUB_RESET;
    end else begin
      esc_r      <= esc_nxt;
      wide_r     <= wide_nxt;
      ul_r       <= ul_nxt;
      raw_left_r <= raw_left_nxt;
      if (cfg_wr) begin
        sub_r <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/pbr_back.sv =====
// back end: owns the font store and line state, emits columns one per cycle while the result queue has room
`default_nettype none

module pbr_back #(
  parameter int GLYPH_WIDTH  = 5,
  parameter int FIRST_CODE   = 32,
  parameter int LINE_COLUMNS = 200
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  wire pbr_pkg::cmd_t q_cmd,
  output logic               q_pop,
  input  wire logic          o_full,
  output logic               o_push,
  output pbr_pkg::res_t      o_item
);

  localparam int STORE_DEPTH = (256 - FIRST_CODE) * GLYPH_WIDTH;
  localparam int RAM_AW      = $clog2(STORE_DEPTH);
  localparam int CW          = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LEAD  = 2'd1;
  localparam logic [1:0] S_GLYPH = 2'd2;
  localparam logic [1:0] S_TRAIL = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic [CW-1:0]               col_r, col_nxt;
  logic                        dup_r, dup_nxt;
  logic [7:0]                  count_r, count_nxt;
  logic                        ovf_r, ovf_nxt;
  logic [pbr_pkg::FONT_AW-1:0] base_r, base_nxt;
  logic                        gvalid_r, gvalid_nxt;
  logic                        wide_r, wide_nxt;
  logic                        ul_r, ul_nxt;

  logic                        ram_we, ram_re;
  logic [pbr_pkg::FONT_AW-1:0] ram_raddr;
  logic [7:0]                  ram_rdata;
  logic                        col_req, col_final, drop, go;
  logic [7:0]                  col_bits, ul_bits, glyph_bits;
  logic [8:0]                  width_up;

  assign ul_bits    = ul_r ? pbr_pkg::ULINE_BIT : '0;
  assign glyph_bits = (gvalid_r ? ram_rdata : '0) | ul_bits;
  assign drop       = (count_r >= 8'(LINE_COLUMNS));
  assign go         = drop || !o_full;
  assign width_up   = ({1'b0, count_r} + 9'd7) & ~9'd7;

  pbr_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_font (
    .clk  (clk),
    .we   (ram_we),
    .waddr(RAM_AW'(q_cmd.addr)),
    .wdata(q_cmd.data),
    .re   (ram_re),
    .raddr(RAM_AW'(ram_raddr)),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    col_nxt    = col_r;
    dup_nxt    = dup_r;
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    base_nxt   = base_r;
    gvalid_nxt = gvalid_r;
    wide_nxt   = wide_r;
    ul_nxt     = ul_r;
    q_pop      = 1'b0;
    o_push     = 1'b0;
    o_item     = '0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = base_r + pbr_pkg::FONT_AW'(col_r) + 1'b1;
    col_req    = 1'b0;
    col_final  = 1'b0;
    col_bits   = ul_bits;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          unique case (q_cmd.code)
            pbr_pkg::CMD_FONT_WR: begin
              ram_we = 1'b1;
              q_pop  = 1'b1;
            end
            pbr_pkg::CMD_CLEAR: begin
              count_nxt = '0;
              ovf_nxt   = 1'b0;
              q_pop     = 1'b1;
            end
            pbr_pkg::CMD_RAW: begin
              col_req   = 1'b1;
              col_final = 1'b1;
              col_bits  = q_cmd.data;
              q_pop     = go;
            end
            pbr_pkg::CMD_LINE_END: begin
              if (!o_full) begin
                q_pop  = 1'b1;
                o_push = 1'b1;
                o_item.last = 1'b1;
                if (count_r == '0) begin
                  o_item.kind = pbr_pkg::KIND_FEED;
                end else begin
                  o_item.kind       = pbr_pkg::KIND_LINE_END;
                  o_item.overflowed = ovf_r;
                  o_item.line_width = (width_up > 9'(LINE_COLUMNS)) ?
                                      8'(LINE_COLUMNS) : width_up[7:0];
                  count_nxt = '0;
                  ovf_nxt   = 1'b0;
                end
              end
            end
            pbr_pkg::CMD_GLYPH: begin
              q_pop      = 1'b1;
              ram_re     = 1'b1;
              ram_raddr  = q_cmd.addr;
              base_nxt   = q_cmd.addr;
              gvalid_nxt = q_cmd.gvalid;
              wide_nxt   = q_cmd.wide;
              ul_nxt     = q_cmd.ul;
              col_nxt    = '0;
              dup_nxt    = 1'b0;
              state_nxt  = (count_r != '0) ? S_LEAD : S_GLYPH;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      S_LEAD: begin
        col_req = 1'b1;
        if (go) begin
          state_nxt = S_GLYPH;
        end
      end
      S_GLYPH: begin
        col_req  = 1'b1;
        col_bits = glyph_bits;
        if (go) begin
          if (wide_r && !dup_r) begin
            dup_nxt = 1'b1;
          end else begin
            dup_nxt = 1'b0;
            if (col_r == CW'(GLYPH_WIDTH - 1)) begin
              state_nxt = S_TRAIL;
            end else begin
              col_nxt = col_r + 1'b1;
              ram_re  = 1'b1;
            end
          end
        end
      end
      S_TRAIL: begin
        col_req   = 1'b1;
        col_final = 1'b1;
        if (go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (col_req && go) begin
      if (drop) begin
        ovf_nxt = 1'b1;
      end else begin
        o_push              = 1'b1;
        o_item.kind         = pbr_pkg::KIND_COLUMN;
        o_item.column_index = count_r;
        o_item.column_bits  = col_bits;
        // the column that fills the line is the last one that survives
        o_item.last         = col_final || (count_r == 8'(LINE_COLUMNS - 1));
        count_nxt           = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r    <= col_nxt;
    dup_r    <= dup_nxt;
    base_r   <= base_nxt;
    gvalid_r <= gvalid_nxt;
    wide_r   <= wide_nxt;
    ul_r     <= ul_nxt;
  end

endmodule

`default_nettype wire

// ===== design/printer_byte_stream_column_renderer.sv =====
// top level of the printer byte stream column renderer
// The front end takes one byte or font write per cycle into a four-entry
// command queue while it is not full; mode-change escapes give no result.
// The back end executes commands in order: a font write, raw column, line end
// or clear is handled in the idle state; a glyph steps through the idle, lead,
// glyph and trail states (no lead at line start, columns doubled when wide),
// each glyph column read from the font store with a registered read and shown
// one per cycle. Results wait in a four-entry queue, so the back end only
// stalls when that queue is full. No clearing pass after reset.
`default_nettype none

module printer_byte_stream_column_renderer #(
  parameter int GLYPH_WIDTH  = 5,
  parameter int FIRST_CODE   = 32,
  parameter int LINE_COLUMNS = 200
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic        in_op,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [10:0] in_font_address,
  input  wire logic [7:0]  in_font_column,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_column_index,
  output logic [7:0]       out_column_bits,
  output logic [7:0]       out_line_width,
  output logic             out_overflowed,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_substitute_code
);

  pbr_pkg::cmd_t fq_wcmd, fq_rcmd;
  pbr_pkg::res_t rq_witem, rq_ritem;
  logic          fq_push, fq_full, fq_pop, fq_empty;
  logic          rq_push, rq_full;

  assign cfg_ready = 1'b1;
  assign in_full   = fq_full;

  pbr_front #(
    .GLYPH_WIDTH(GLYPH_WIDTH),
    .FIRST_CODE (FIRST_CODE)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_op          (in_op),
    .in_data_byte   (in_data_byte),
    .in_font_address(in_font_address),
    .in_font_column (in_font_column),
    .cfg_wr         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_substitute_code),
    .q_full         (fq_full),
    .q_push         (fq_push),
    .q_cmd          (fq_wcmd)
  );

  pbr_fifo #(
    .WIDTH($bits(pbr_pkg::cmd_t)),
    .DEPTH(pbr_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (fq_push),
    .wdata(fq_wcmd),
    .full (fq_full),
    .pop  (fq_pop),
    .rdata(fq_rcmd),
    .empty(fq_empty)
  );

  pbr_back #(
    .GLYPH_WIDTH (GLYPH_WIDTH),
    .FIRST_CODE  (FIRST_CODE),
    .LINE_COLUMNS(LINE_COLUMNS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_empty(fq_empty),
    .q_cmd  (fq_rcmd),
    .q_pop  (fq_pop),
    .o_full (rq_full),
    .o_push (rq_push),
    .o_item (rq_witem)
  );

  pbr_fifo #(
    .WIDTH($bits(pbr_pkg::res_t)),
    .DEPTH(pbr_pkg::OUT_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (rq_push),
    .wdata(rq_witem),
    .full (rq_full),
    .pop  (out_pop),
    .rdata(rq_ritem),
    .empty(out_empty)
  );

  assign out_kind         = rq_ritem.kind;
  assign out_column_index = rq_ritem.column_index;
  assign out_column_bits  = rq_ritem.column_bits;
  assign out_line_width   = rq_ritem.line_width;
  assign out_overflowed   = rq_ritem.overflowed;
  assign out_last         = rq_ritem.last;

endmodule

`default_nettype wire

// ===== design/pbr_checker.sv =====
// port-level checks of the column renderer and their bind
`default_nettype none

module pbr_checker #(
  parameter int LINE_COLUMNS = 200
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [1:0]  out_kind,
  input wire logic [7:0]  out_column_index,
  input wire logic [7:0]  out_column_bits,
  input wire logic [7:0]  out_line_width,
  input wire logic        out_overflowed,
  input wire logic        out_last
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_kind)
      && $stable(out_column_index) && $stable(out_column_bits) && $stable(out_last))
    else $error("waiting result changed");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_kind == pbr_pkg::KIND_COLUMN
      |-> out_column_index < 8'(LINE_COLUMNS) && out_line_width == '0 && !out_overflowed)
    else $error("column result out of range");

  a_line_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_kind != pbr_pkg::KIND_COLUMN
      |-> out_last && out_column_index == '0 && out_column_bits == '0)
    else $error("line end or feed malformed");

  a_width: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_kind == pbr_pkg::KIND_LINE_END
      |-> out_line_width != '0
        && (out_line_width[2:0] == 3'd0 || out_line_width == 8'(LINE_COLUMNS)))
    else $error("line width not padded");

endmodule

bind printer_byte_stream_column_renderer pbr_checker #(
  .LINE_COLUMNS(LINE_COLUMNS)
) u_pbr_checker (.*);

`default_nettype wire

// ===== tb/tb_printer_byte_stream_column_renderer.sv =====
// testbench of the printer byte stream column renderer: queue-side stimulus and column checks
`timescale 1ns / 1ps

module tb_printer_byte_stream_column_renderer;

  localparam int GLYPH_WIDTH    = 5;
  localparam int FIRST_CODE     = 32;
  localparam int LINE_COLUMNS   = 200;
  localparam int STORE_DEPTH    = (256 - FIRST_CODE) * GLYPH_WIDTH;
  localparam int ADDR_MAX       = 2047;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int PRINT_LIMIT    = 40;
  localparam int GLYPH_SET      = 8;
  localparam int RANDOM_ITEMS   = 15;

  localparam logic [7:0] ESC_SELFTEST  = 8'd254;
  localparam logic [7:0] ESC_ZERO      = 8'd0;
  localparam logic [7:0] ESC_SUB_FIRST = 8'd167;
  localparam logic [7:0] ESC_SUB_LAST  = 8'd247;
  localparam logic [7:0] CHAR_A        = 8'd65;
  localparam logic [7:0] CHAR_LAST     = 8'd255;
  localparam logic [7:0] CTRL_LAST     = 8'd31;

  typedef struct {
    logic        op;
    logic [7:0]  data_byte;
    logic [10:0] font_address;
    logic [7:0]  font_column;
  } stream_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic        in_op = 1'b0;
  logic [7:0]  in_data_byte = 8'd0;
  logic [10:0] in_font_address = 11'd0;
  logic [7:0]  in_font_column = 8'd0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_column_index;
  logic [7:0]  out_column_bits;
  logic [7:0]  out_line_width;
  logic        out_overflowed;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_substitute_code = 8'd0;

  stream_item_t   stream_items[$];
  stream_item_t   next_item;
  pbr_pkg::res_t  due_results[$];
  pbr_pkg::res_t  head;

  logic        quiet = 1'b0;
  logic        rx_hold_req = 1'b0;
  int          rx_hold_left = 0;
  int          stall_cycles = 0;
  int          errors = 0;

  // shadow of the renderer state
  logic [7:0]  font_img [0:STORE_DEPTH-1];
  int          line_cols = 0;
  logic        esc_pending = 1'b0;
  logic        wide_on = 1'b0;
  logic        uline_on = 1'b0;
  int          raw_left = 0;
  logic        line_ovf = 1'b0;
  logic [7:0]  sub_code = pbr_pkg::SUB_RESET;

  printer_byte_stream_column_renderer #(
    .GLYPH_WIDTH(GLYPH_WIDTH),
    .FIRST_CODE(FIRST_CODE),
    .LINE_COLUMNS(LINE_COLUMNS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_op(in_op),
    .in_data_byte(in_data_byte),
    .in_font_address(in_font_address),
    .in_font_column(in_font_column),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_kind(out_kind),
    .out_column_index(out_column_index),
    .out_column_bits(out_column_bits),
    .out_line_width(out_line_width),
    .out_overflowed(out_overflowed),
    .out_last(out_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_substitute_code(cfg_substitute_code)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string field, input int got, input int want);
    if (errors < PRINT_LIMIT)
      $display("mismatch %s: got %0d want %0d", field, got, want);
    errors++;
  endtask

  task automatic put_result(input logic [1:0] kind, input int idx, input logic [7:0] bits,
                            input int width, input logic ovf);
    pbr_pkg::res_t r;
    r.kind = kind;
    r.column_index = idx[7:0];
    r.column_bits = bits;
    r.line_width = width[7:0];
    r.overflowed = ovf;
    r.last = 1'b0;
    due_results.push_back(r);
  endtask

  task automatic put_column(input logic [7:0] bits);
    if (line_cols >= LINE_COLUMNS) begin
      line_ovf = 1'b1;
    end else begin
      put_result(pbr_pkg::KIND_COLUMN, line_cols, bits, 0, 1'b0);
      line_cols++;
    end
  endtask

  function automatic logic [7:0] glyph_bits(input logic [7:0] code, input int col);
    if (code < FIRST_CODE)
      return 8'd0;
    return font_img[(code - FIRST_CODE) * GLYPH_WIDTH + col];
  endfunction

  task automatic draw_char(input logic [7:0] code);
    logic [7:0] ul;
    logic [7:0] bits;
    ul = uline_on ? pbr_pkg::ULINE_BIT : 8'd0;
    if (line_cols != 0)
      put_column(ul);
    for (int i = 0; i < GLYPH_WIDTH; i++) begin
      bits = glyph_bits(code, i) | ul;
      put_column(bits);
      if (wide_on)
        put_column(bits);
    end
    put_column(ul);
  endtask

  task automatic render_item(input logic op, input logic [7:0] c, input logic [10:0] addr,
                             input logic [7:0] fbits);
    int            n_prior;
    int            w;
    pbr_pkg::res_t tail;
    n_prior = due_results.size();
    if (op) begin
      if (addr < STORE_DEPTH)
        font_img[addr] = fbits;
    end else if (raw_left == 0 && c == pbr_pkg::ESC_CODE) begin
      esc_pending = 1'b1;
    end else if (esc_pending) begin
      esc_pending = 1'b0;
      if (c == pbr_pkg::ESC_RESET) begin
        line_cols = 0;
        wide_on = 1'b0;
        uline_on = 1'b0;
        raw_left = 0;
        line_ovf = 1'b0;
      end else if (c == pbr_pkg::ESC_WIDE) begin
        wide_on = 1'b1;
      end else if (c == pbr_pkg::ESC_NARROW) begin
        wide_on = 1'b0;
      end else if (c == pbr_pkg::ESC_ULINE) begin
        uline_on = 1'b1;
      end else if (c == pbr_pkg::ESC_NO_ULINE) begin
        uline_on = 1'b0;
      end else if (c >= pbr_pkg::ESC_NOP_MIN) begin
      end else if (c >= 8'd1 && c <= pbr_pkg::RAW_MAX) begin
        raw_left = int'(c);
      end else begin
        draw_char(sub_code);
      end
    end else if (raw_left != 0) begin
      put_column(c);
      raw_left--;
    end else if (c == pbr_pkg::CODE_EOT || c == pbr_pkg::CODE_LF) begin
      if (line_cols == 0) begin
        put_result(pbr_pkg::KIND_FEED, 0, 8'd0, 0, 1'b0);
      end else begin
        w = ((line_cols + 7) / 8) * 8;
        if (w > LINE_COLUMNS)
          w = LINE_COLUMNS;
        put_result(pbr_pkg::KIND_LINE_END, 0, 8'd0, w, line_ovf);
        line_cols = 0;
        line_ovf = 1'b0;
      end
    end else if (c >= FIRST_CODE) begin
      draw_char(c);
    end else begin
      draw_char(sub_code);
    end
    if (due_results.size() > n_prior) begin
      tail = due_results[due_results.size() - 1];
      tail.last = 1'b1;
      due_results[due_results.size() - 1] = tail;
    end
  endtask

  task automatic queue_byte(input logic [7:0] b);
    stream_item_t it;
    it.op = 1'b0;
    it.data_byte = b;
    it.font_address = 11'($urandom_range(ADDR_MAX));
    it.font_column = 8'($urandom_range(255));
    stream_items.push_back(it);
  endtask

  task automatic queue_font(input int addr, input logic [7:0] v);
    stream_item_t it;
    it.op = 1'b1;
    it.data_byte = 8'($urandom_range(255));
    it.font_address = addr[10:0];
    it.font_column = v;
    stream_items.push_back(it);
  endtask

  // loads every column of one glyph
  task automatic queue_glyph_font(input logic [7:0] code);
    for (int i = 0; i < GLYPH_WIDTH; i++)
      queue_font((int'(code) - FIRST_CODE) * GLYPH_WIDTH + i, 8'($urandom_range(255)));
  endtask

  // glyph codes whose font columns are loaded
  function automatic logic [7:0] pick_glyph();
    case ($urandom_range(3))
      0: return 8'(FIRST_CODE);
      1: return CHAR_LAST;
      2: return pbr_pkg::SUB_RESET;
      default: return CHAR_A + 8'($urandom_range(GLYPH_SET - 1));
    endcase
  endfunction

  function automatic logic [7:0] pick_escape();
    case ($urandom_range(9))
      0: return pbr_pkg::ESC_RESET;
      1: return pbr_pkg::ESC_WIDE;
      2: return pbr_pkg::ESC_NARROW;
      3: return pbr_pkg::ESC_ULINE;
      4: return pbr_pkg::ESC_NO_ULINE;
      5: return ($urandom_range(2) == 0) ? ESC_SELFTEST
                                         : 8'($urandom_range(249, pbr_pkg::ESC_NOP_MIN));
      6: return ESC_ZERO;
      7: return 8'($urandom_range(ESC_SUB_LAST, ESC_SUB_FIRST));
      8: return pbr_pkg::ESC_NARROW;
      default: return pbr_pkg::ESC_NO_ULINE;
    endcase
  endfunction

  task automatic queue_random(input int n);
    int count;
    int r;
    int k;
    count = 0;
    while (count < n) begin
      r = $urandom_range(99);
      if (r < 55) begin
        queue_byte(pick_glyph());
        count++;
      end else if (r < 63) begin
        queue_byte(($urandom_range(1) == 0) ? pbr_pkg::CODE_LF : pbr_pkg::CODE_EOT);
        count++;
      end else if (r < 75) begin
        queue_byte(pbr_pkg::ESC_CODE);
        queue_byte(pick_escape());
        count += 2;
      end else if (r < 83) begin
        k = $urandom_range(8, 1);
        queue_byte(pbr_pkg::ESC_CODE);
        queue_byte(k[7:0]);
        for (int i = 0; i < k; i++)
          queue_byte(8'($urandom_range(255)));
        count += k + 2;
      end else if (r < 90) begin
        queue_font($urandom_range(ADDR_MAX), 8'($urandom_range(255)));
        count++;
      end else begin
        k = $urandom_range(CTRL_LAST);
        queue_byte((k == int'(pbr_pkg::ESC_CODE)) ? ESC_ZERO : k[7:0]);
        count++;
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (stream_items.size() != 0 || in_push || due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_substitute(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_substitute_code <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sub_code = v;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full)
        render_item(in_op, in_data_byte, in_font_address, in_font_column);
      if (!in_push || !in_full) begin
        if (stream_items.size() != 0 && (quiet || $urandom_range(99) >= 9)) begin
          next_item = stream_items.pop_front();
          in_push <= 1'b1;
          in_op <= next_item.op;
          in_data_byte <= next_item.data_byte;
          in_font_address <= next_item.font_address;
          in_font_column <= next_item.font_column;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // receiver hold-off counter
  always @(posedge clk) begin
    if (rx_hold_req)
      rx_hold_left <= RX_HOLD_CYCLES;
    else if (rx_hold_left != 0)
      rx_hold_left <= rx_hold_left - 1;
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with none due, kind", int'(out_kind), -1);
        end else begin
          head = due_results.pop_front();
          if (out_kind !== head.kind)
            report_mismatch("kind", int'(out_kind), int'(head.kind));
          if (out_column_index !== head.column_index)
            report_mismatch("column_index", int'(out_column_index),
                            int'(head.column_index));
          if (out_column_bits !== head.column_bits)
            report_mismatch("column_bits", int'(out_column_bits), int'(head.column_bits));
          if (out_line_width !== head.line_width)
            report_mismatch("line_width", int'(out_line_width), int'(head.line_width));
          if (out_overflowed !== head.overflowed)
            report_mismatch("overflowed", int'(out_overflowed), int'(head.overflowed));
          if (out_last !== head.last)
            report_mismatch("last", int'(out_last), int'(head.last));
        end
      end
      out_pop <= (rx_hold_left == 0) && (quiet || $urandom_range(99) >= 9);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    for (int a = 0; a < STORE_DEPTH; a++)
      font_img[a] = 8'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // font load of the glyphs in use, plus writes past the store
    queue_glyph_font(8'(FIRST_CODE));
    for (int i = 0; i < GLYPH_SET; i++)
      queue_glyph_font(CHAR_A + 8'(i));
    queue_glyph_font(pbr_pkg::SUB_RESET);
    queue_glyph_font(CHAR_LAST);
    queue_font(STORE_DEPTH, 8'hFF);
    queue_font(ADDR_MAX, 8'hFF);
    wait_drained();

    // directed items with the reset substitute
    queue_byte(CHAR_A);
    queue_byte(pbr_pkg::ESC_CODE); queue_byte(pbr_pkg::ESC_WIDE);
    queue_byte(CHAR_A + 8'd1);
    queue_byte(pbr_pkg::ESC_CODE); queue_byte(pbr_pkg::ESC_ULINE);
    queue_byte(CHAR_A + 8'd2);
    queue_byte(pbr_pkg::ESC_CODE); queue_byte(pbr_pkg::ESC_NARROW);
    queue_byte(pbr_pkg::ESC_CODE); queue_byte(pbr_pkg::ESC_NO_ULINE);
    queue_byte(ESC_ZERO);
    queue_byte(CTRL_LAST);
    queue_byte(CHAR_LAST);
    queue_byte(pbr_pkg::CODE_LF);
    queue_byte(pbr_pkg::CODE_LF);
    queue_byte(pbr_pkg::ESC_CODE); queue_byte(ESC_ZERO);
    queue_byte(pbr_pkg::ESC_CODE); queue_byte(ESC_SUB_LAST);
    queue_byte(pbr_pkg::ESC_CODE); queue_byte(ESC_SELFTEST);
    queue_byte(pbr_pkg::ESC_CODE); queue_byte(pbr_pkg::ESC_CODE); queue_byte(CHAR_A);
    queue_byte(pbr_pkg::ESC_CODE); queue_byte(8'd1); queue_byte(pbr_pkg::ESC_CODE);
    queue_byte(pbr_pkg::ESC_CODE); queue_byte(pbr_pkg::ESC_RESET);
    queue_byte(CHAR_A + 8'd7);
    queue_byte(pbr_pkg::CODE_EOT);
    wait_drained();

    // receiver held off while wide glyphs overflow the line, then raw column runs
    load_substitute(8'd0);
    rx_hold_req <= 1'b1;
    @(posedge clk);
    rx_hold_req <= 1'b0;
    queue_byte(pbr_pkg::ESC_CODE); queue_byte(pbr_pkg::ESC_WIDE);
    queue_byte(pbr_pkg::ESC_CODE); queue_byte(pbr_pkg::ESC_ULINE);
    for (int i = 0; i < 20; i++)
      queue_byte(pick_glyph());
    queue_byte(ESC_ZERO);
    queue_byte(pbr_pkg::CODE_LF);
    queue_byte(pbr_pkg::ESC_CODE); queue_byte(pbr_pkg::ESC_NO_ULINE);
    queue_byte(pbr_pkg::ESC_CODE); queue_byte(pbr_pkg::ESC_NARROW);
    queue_byte(pbr_pkg::ESC_CODE); queue_byte(pbr_pkg::RAW_MAX);
    queue_byte(pbr_pkg::ESC_CODE);
    queue_byte(CHAR_LAST);
    for (int i = 2; i < pbr_pkg::RAW_MAX; i++)
      queue_byte(8'($urandom_range(255)));
    for (int i = 0; i < 4; i++)
      queue_byte(pick_glyph());
    queue_byte(pbr_pkg::ESC_CODE); queue_byte(8'd3);
    queue_byte(8'hFF); queue_byte(8'h00); queue_byte(pbr_pkg::ULINE_BIT);
    queue_byte(pbr_pkg::CODE_LF);
    wait_drained();

    load_substitute(8'd255);
    quiet <= 1'b1;
    queue_random(RANDOM_ITEMS);
    wait_drained();
    quiet <= 1'b0;

    load_substitute(pick_glyph());
    queue_random(RANDOM_ITEMS);
    wait_drained();

    load_substitute(CTRL_LAST);
    queue_random(RANDOM_ITEMS);
    wait_drained();

    load_substitute(8'(FIRST_CODE));
    queue_random(RANDOM_ITEMS);
    wait_drained();

    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
